// ===== design/mtps_pkg.sv =====
// Shared constants for the terrain-map pixel shader.
`timescale 1ns / 1ps
`default_nettype none

package mtps_pkg;

  localparam logic CMD_SHADE = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] SHADE_DARK   = 2'd0;
  localparam logic [1:0] SHADE_NORMAL = 2'd1;
  localparam logic [1:0] SHADE_BRIGHT = 2'd2;

  localparam logic [1:0] REG_CHUNK_GRID_ON     = 2'd0;
  localparam logic [1:0] REG_TILE_GRID_ON      = 2'd1;
  localparam logic [1:0] REG_UNEXPLORED_COLOUR = 2'd2;
  localparam logic [1:0] REG_TILE_GRID_COLOUR  = 2'd3;

  localparam logic [8:0] WATER_BRIGHT_BELOW = 9'd5;
  localparam logic [8:0] WATER_DARK_ABOVE   = 9'd9;
  localparam logic [8:0] WATER_DITHER       = 9'd2;

  localparam int FLAG_KNOWN = 0;
  localparam int FLAG_WATER = 1;

endpackage

`default_nettype wire

// ===== design/map_tile_pixel_shader_unit.sv =====
// Terrain-map pixel shader: palette RAM, column height tracking, grid overlay.
// Input channel (in_valid / in_stall) carries one word per item: either a
// palette write (in_command = 1) or one pixel to shade (in_command = 0).
// Pixels of a column arrive northmost row first; each pixel leaves its height
// as the previous height for the next pixel. Writes give no result word.
// Result channel (out_valid / out_stall) carries one colour word per pixel.
// Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while the block is idle.
// A pixel accepted is registered in stage 1, then in the result register that drives out_colour.
// Throughput: one word per cycle unless stalled; the palette RAMs are read once
// at accept time, the shade select and grid overlay run in the cycle after.
// Reset (rst_n low, synchronous) clears the palette known bits, the previous
// height, the configuration registers and both pipeline valids.
// When the receiver stalls, the result holds; stage 1, if empty, still takes
// one more pixel, then in_stall rises until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module map_tile_pixel_shader_unit #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [15:0] in_block_id,
  input  wire logic [7:0]  in_height,
  input  wire logic [7:0]  in_water_depth,
  input  wire logic [3:0]  in_local_x,
  input  wire logic [3:0]  in_local_z,
  input  wire logic [1:0]  in_tile_edges,
  input  wire logic        in_north_known,
  input  wire logic [7:0]  in_north_height,
  input  wire logic [15:0] in_entry_colour,
  input  wire logic [1:0]  in_entry_shade,
  input  wire logic [1:0]  in_entry_flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_colour,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // configuration registers
  logic        chunk_grid_on_r;
  logic        tile_grid_on_r;
  logic [15:0] unexplored_colour_r;
  logic [15:0] tile_grid_colour_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_grid_on_r     <= 1'b0;
      tile_grid_on_r      <= 1'b0;
      unexplored_colour_r <= 16'd0;
      tile_grid_colour_r  <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtps_pkg::REG_CHUNK_GRID_ON:     chunk_grid_on_r     <= cfg_data[0];
        mtps_pkg::REG_TILE_GRID_ON:      tile_grid_on_r      <= cfg_data[0];
        mtps_pkg::REG_UNEXPLORED_COLOUR: unexplored_colour_r <= cfg_data;
        mtps_pkg::REG_TILE_GRID_COLOUR:  tile_grid_colour_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic s1_free;
  logic in_accept;
  logic pix_accept;
  logic wr_accept;

  assign out_adv    = !out_valid_r || !out_stall;
  assign s1_free    = !s1_valid_r || out_adv;
  assign in_stall   = !s1_free;
  assign in_accept  = in_valid && s1_free;
  assign pix_accept = in_accept && (in_command == mtps_pkg::CMD_SHADE);
  assign wr_accept  = in_accept && (in_command == mtps_pkg::CMD_WRITE);

  logic          in_range;
  logic [AW-1:0] addr;

  assign in_range = {1'b0, in_block_id} < 17'(PALETTE_ENTRIES);
  assign addr     = in_block_id[AW-1:0];

  // palette storage: known bits in flops, flags and three shade slots in RAM
  logic [PALETTE_ENTRIES-1:0] known_r;
  logic [1:0]                 flag_mem  [PALETTE_ENTRIES];
  logic [15:0]                dark_mem  [PALETTE_ENTRIES];
  logic [15:0]                norm_mem  [PALETTE_ENTRIES];
  logic [15:0]                brt_mem   [PALETTE_ENTRIES];

  logic [1:0]  s1_flags_r;
  logic [15:0] s1_dark_r;
  logic [15:0] s1_norm_r;
  logic [15:0] s1_brt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
    end else if (wr_accept && in_range) begin
      known_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_accept && in_range) begin
      flag_mem[addr] <= in_entry_flags;
    end
    if (pix_accept) begin
      s1_flags_r <= flag_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_accept && in_range && (in_entry_shade == mtps_pkg::SHADE_DARK)) begin
      dark_mem[addr] <= in_entry_colour;
    end
    if (pix_accept) begin
      s1_dark_r <= dark_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_accept && in_range && (in_entry_shade == mtps_pkg::SHADE_NORMAL)) begin
      norm_mem[addr] <= in_entry_colour;
    end
    if (pix_accept) begin
      s1_norm_r <= norm_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_accept && in_range && (in_entry_shade == mtps_pkg::SHADE_BRIGHT)) begin
      brt_mem[addr] <= in_entry_colour;
    end
    if (pix_accept) begin
      s1_brt_r <= brt_mem[addr];
    end
  end

  // previous height in the column
  logic [7:0] prev_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_height_r <= 8'd0;
    end else if (pix_accept) begin
      prev_height_r <= in_height;
    end
  end

  // stage 1 pixel fields
  logic       s1_known_r;
  logic [7:0] s1_height_r;
  logic [7:0] s1_before_r;
  logic       s1_before_known_r;
  logic [7:0] s1_depth_r;
  logic       s1_odd_r;
  logic       s1_x_zero_r;
  logic       s1_z_zero_r;
  logic [1:0] s1_edges_r;
  logic       lz_zero;

  assign lz_zero = in_local_z == 4'd0;

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_known_r        <= in_range && known_r[addr];
      s1_height_r       <= in_height;
      s1_before_r       <= lz_zero ? in_north_height : prev_height_r;
      s1_before_known_r <= lz_zero ? in_north_known : 1'b1;
      s1_depth_r        <= in_water_depth;
      s1_odd_r          <= in_local_x[0] ^ in_local_z[0];
      s1_x_zero_r       <= in_local_x == 4'd0;
      s1_z_zero_r       <= lz_zero;
      s1_edges_r        <= in_tile_edges;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= pix_accept;
    end
  end

  // shade select and grid overlay
  logic [8:0]  tenths;
  logic [1:0]  water_shade;
  logic [1:0]  land_shade;
  logic [1:0]  shade;
  logic        id_known;
  logic [15:0] colour_nxt;

  always_comb begin
    tenths = {1'b0, s1_depth_r} + (s1_odd_r ? mtps_pkg::WATER_DITHER : 9'd0);
    if (tenths < mtps_pkg::WATER_BRIGHT_BELOW) begin
      water_shade = mtps_pkg::SHADE_BRIGHT;
    end else if (tenths > mtps_pkg::WATER_DARK_ABOVE) begin
      water_shade = mtps_pkg::SHADE_DARK;
    end else begin
      water_shade = mtps_pkg::SHADE_NORMAL;
    end

    if (!s1_before_known_r || (s1_height_r == s1_before_r)) begin
      land_shade = mtps_pkg::SHADE_NORMAL;
    end else if (s1_height_r > s1_before_r) begin
      land_shade = mtps_pkg::SHADE_BRIGHT;
    end else begin
      land_shade = mtps_pkg::SHADE_DARK;
    end

    shade    = s1_flags_r[mtps_pkg::FLAG_WATER] ? water_shade : land_shade;
    id_known = s1_known_r && s1_flags_r[mtps_pkg::FLAG_KNOWN];

    colour_nxt = unexplored_colour_r;
    if (id_known) begin
      case (shade)
        mtps_pkg::SHADE_DARK:   colour_nxt = s1_dark_r;
        mtps_pkg::SHADE_BRIGHT: colour_nxt = s1_brt_r;
        default:                colour_nxt = s1_norm_r;
      endcase
      if (chunk_grid_on_r && (s1_x_zero_r || s1_z_zero_r)) begin
        colour_nxt = s1_dark_r;
      end
    end
    if (tile_grid_on_r && ((s1_edges_r[0] && s1_x_zero_r) ||
                           (s1_edges_r[1] && s1_z_zero_r))) begin
      colour_nxt = tile_grid_colour_r;
    end
  end

  // result register
  logic [15:0] out_colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_colour_r <= colour_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_colour = out_colour_r;

  a_known_set: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_accept && in_range) |=> known_r[$past(addr)])
    else $error("palette known bit not set after write");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("stage 1 pixel lost");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline valid not cleared by reset");

endmodule

`default_nettype wire

// ===== tb/sv/tb_map_tile_pixel_shader_unit.sv =====
// Self-checking testbench for the terrain-map pixel shader: scoreboard, drivers, monitors.
`timescale 1ns / 1ps

module tb_map_tile_pixel_shader_unit;

  localparam int ENTRIES = 256;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_WORDS = 400;

  typedef struct packed {
    logic        command;
    logic [15:0] block_id;
    logic [7:0]  height;
    logic [7:0]  water_depth;
    logic [3:0]  local_x;
    logic [3:0]  local_z;
    logic [1:0]  tile_edges;
    logic        north_known;
    logic [7:0]  north_height;
    logic [15:0] entry_colour;
    logic [1:0]  entry_shade;
    logic [1:0]  entry_flags;
  } shader_word_t;

  class colour_scoreboard;
    logic [15:0] pal_colour [3*ENTRIES];
    logic [1:0]  pal_flags [ENTRIES];
    logic [7:0]  last_height;
    logic        chunk_grid;
    logic        tile_grid;
    logic [15:0] unexplored;
    logic [15:0] grid_colour;
    logic [15:0] colour_q [$];
    int          mismatches;

    function new();
      for (int i = 0; i < 3*ENTRIES; i++) pal_colour[i] = '0;
      for (int i = 0; i < ENTRIES; i++) pal_flags[i] = '0;
      last_height = '0;
      chunk_grid = 1'b0;
      tile_grid = 1'b0;
      unexplored = '0;
      grid_colour = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        mtps_pkg::REG_CHUNK_GRID_ON:     chunk_grid = data[0];
        mtps_pkg::REG_TILE_GRID_ON:      tile_grid = data[0];
        mtps_pkg::REG_UNEXPLORED_COLOUR: unexplored = data;
        mtps_pkg::REG_TILE_GRID_COLOUR:  grid_colour = data;
        default: ;
      endcase
    endfunction

    function logic [1:0] water_shade(logic [7:0] depth, logic [3:0] lx, logic [3:0] lz);
      logic [8:0] tenths;
      tenths = {1'b0, depth} + ((lx[0] ^ lz[0]) ? mtps_pkg::WATER_DITHER : 9'd0);
      if (tenths < mtps_pkg::WATER_BRIGHT_BELOW) return mtps_pkg::SHADE_BRIGHT;
      if (tenths > mtps_pkg::WATER_DARK_ABOVE) return mtps_pkg::SHADE_DARK;
      return mtps_pkg::SHADE_NORMAL;
    endfunction

    function void note_word(shader_word_t w);
      logic        ref_known;
      logic [7:0]  ref_height;
      logic [1:0]  shade;
      logic [15:0] colour;
      int          id;
      id = int'(w.block_id);
      if (w.command == mtps_pkg::CMD_WRITE) begin
        if (id < ENTRIES) begin
          pal_flags[id] = w.entry_flags;
          if (w.entry_shade <= mtps_pkg::SHADE_BRIGHT)
            pal_colour[int'(w.entry_shade)*ENTRIES + id] = w.entry_colour;
        end
        return;
      end
      if (w.local_z == 4'd0) begin
        ref_known = w.north_known;
        ref_height = w.north_height;
      end else begin
        ref_known = 1'b1;
        ref_height = last_height;
      end
      colour = unexplored;
      if (id < ENTRIES && pal_flags[id][mtps_pkg::FLAG_KNOWN]) begin
        if (pal_flags[id][mtps_pkg::FLAG_WATER]) begin
          shade = water_shade(w.water_depth, w.local_x, w.local_z);
        end else if (!ref_known || w.height == ref_height) begin
          shade = mtps_pkg::SHADE_NORMAL;
        end else begin
          shade = (w.height > ref_height) ? mtps_pkg::SHADE_BRIGHT : mtps_pkg::SHADE_DARK;
        end
        colour = pal_colour[int'(shade)*ENTRIES + id];
        if (chunk_grid && (w.local_x == 4'd0 || w.local_z == 4'd0)) colour = pal_colour[id];
      end
      if (tile_grid && ((w.tile_edges[0] && w.local_x == 4'd0) ||
                        (w.tile_edges[1] && w.local_z == 4'd0))) colour = grid_colour;
      last_height = w.height;
      colour_q.push_back(colour);
    endfunction

    function void check_colour(logic [15:0] got);
      logic [15:0] want;
      if (colour_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected colour word %h with nothing pending", got);
        return;
      end
      want = colour_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("colour mismatch: expected %h, actual %h", want, got);
      end
    endfunction

    function int pending();
      return colour_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [15:0] in_block_id;
  logic [7:0]  in_height;
  logic [7:0]  in_water_depth;
  logic [3:0]  in_local_x;
  logic [3:0]  in_local_z;
  logic [1:0]  in_tile_edges;
  logic        in_north_known;
  logic [7:0]  in_north_height;
  logic [15:0] in_entry_colour;
  logic [1:0]  in_entry_shade;
  logic [1:0]  in_entry_flags;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_colour;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  map_tile_pixel_shader_unit #(.PALETTE_ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_block_id(in_block_id), .in_height(in_height),
    .in_water_depth(in_water_depth), .in_local_x(in_local_x), .in_local_z(in_local_z),
    .in_tile_edges(in_tile_edges), .in_north_known(in_north_known),
    .in_north_height(in_north_height), .in_entry_colour(in_entry_colour),
    .in_entry_shade(in_entry_shade), .in_entry_flags(in_entry_flags),
    .out_valid(out_valid), .out_stall(out_stall), .out_colour(out_colour),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  colour_scoreboard sb = new();
  bit idle_on;
  bit slot_loaded [3*ENTRIES];
  int words_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_word('{in_command, in_block_id, in_height, in_water_depth, in_local_x,
                     in_local_z, in_tile_edges, in_north_known, in_north_height,
                     in_entry_colour, in_entry_shade, in_entry_flags});
    end
    if (rst_n && out_valid && !out_stall) sb.check_colour(out_colour);
    if (rst_n && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("tb_map_tile_pixel_shader_unit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic shader_word_t noise_word();
    shader_word_t w;
    w = shader_word_t'(72'({$urandom, $urandom, $urandom}));
    return w;
  endfunction

  // A known entry always has all three colour slots loaded.
  function automatic shader_word_t write_word(logic [15:0] id, logic [1:0] shade,
                                              logic [15:0] colour, logic [1:0] flags);
    shader_word_t w;
    int i;
    w = noise_word();
    i = int'(id);
    w.command = mtps_pkg::CMD_WRITE;
    w.block_id = id;
    w.entry_shade = shade;
    w.entry_colour = colour;
    w.entry_flags = flags;
    if (i < ENTRIES) begin
      if (shade <= mtps_pkg::SHADE_BRIGHT) slot_loaded[int'(shade)*ENTRIES + i] = 1'b1;
      if (!(slot_loaded[i] && slot_loaded[ENTRIES + i] && slot_loaded[2*ENTRIES + i]))
        w.entry_flags[mtps_pkg::FLAG_KNOWN] = 1'b0;
    end
    return w;
  endfunction

  function automatic shader_word_t pixel_word(logic [15:0] id, logic [7:0] h, logic [7:0] depth,
                                              logic [3:0] lx, logic [3:0] lz, logic [1:0] edges,
                                              logic nk, logic [7:0] nh);
    shader_word_t w;
    w = noise_word();
    w.command = mtps_pkg::CMD_SHADE;
    w.block_id = id;
    w.height = h;
    w.water_depth = depth;
    w.local_x = lx;
    w.local_z = lz;
    w.tile_edges = edges;
    w.north_known = nk;
    w.north_height = nh;
    return w;
  endfunction

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 15));
    if (r < 78) return 16'($urandom_range(250, 255));
    if (r < 90) return 16'($urandom_range(0, ENTRIES - 1));
    if (r < 94) return 16'(ENTRIES);
    if (r < 96) return 16'hFFFF;
    return 16'($urandom_range(ENTRIES, 65535));
  endfunction

  task automatic send_word(shader_word_t w);
    in_command <= w.command;
    in_block_id <= w.block_id;
    in_height <= w.height;
    in_water_depth <= w.water_depth;
    in_local_x <= w.local_x;
    in_local_z <= w.local_z;
    in_tile_edges <= w.tile_edges;
    in_north_known <= w.north_known;
    in_north_height <= w.north_height;
    in_entry_colour <= w.entry_colour;
    in_entry_shade <= w.entry_shade;
    in_entry_flags <= w.entry_flags;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic load_entry(logic [15:0] id, logic [1:0] flags);
    int first;
    first = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      send_word(write_word(id, 2'((first + k) % 3), 16'($urandom), flags));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic cg, logic tg, logic [15:0] unexp, logic [15:0] gcol);
    logic [15:0] vals [4];
    vals[0] = {15'd0, cg};
    vals[1] = {15'd0, tg};
    vals[2] = unexp;
    vals[3] = gcol;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_column();
    logic [3:0] lx;
    logic [1:0] edges;
    logic       nk;
    logic [7:0] nh;
    logic [7:0] h;
    logic [7:0] depth;
    int         z0;
    int         len;
    lx = 4'($urandom);
    edges = 2'($urandom);
    nk = 1'($urandom);
    nh = 8'($urandom);
    h = ($urandom_range(0, 3) == 0) ? nh : 8'($urandom);
    z0 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 0;
    len = $urandom_range(1, 16 - z0);
    for (int z = z0; z < z0 + len; z++) begin
      case ($urandom_range(0, 5))
        0: h = h + 8'd1;
        1: h = h - 8'd1;
        2: h = 8'($urandom);
        default: ;
      endcase
      depth = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 12)) : 8'($urandom);
      send_word(pixel_word(pick_id(), h, depth, lx, 4'(z), edges, nk, nh));
    end
  endtask

  task automatic random_phase(int n);
    int start;
    int r;
    shader_word_t w;
    start = words_sent;
    while (words_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        load_entry(pick_id(), 2'($urandom));
      end else if (r < 80) begin
        send_column();
      end else if (r < 90) begin
        w = noise_word();
        w.command = mtps_pkg::CMD_SHADE;
        if ($urandom_range(0, 1)) w.block_id = pick_id();
        send_word(w);
      end else begin
        send_word(write_word(pick_id(), 2'($urandom), 16'($urandom), 2'($urandom)));
      end
    end
  endtask

  initial begin
    logic [15:0] rand_unexp;
    logic [15:0] rand_gcol;
    for (int i = 0; i < 3*ENTRIES; i++) slot_loaded[i] = 1'b0;
    words_sent = 0;
    idle_on = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    send_word_defaults: begin
      in_command <= mtps_pkg::CMD_SHADE;
      in_block_id <= '0;
      in_height <= '0;
      in_water_depth <= '0;
      in_local_x <= '0;
      in_local_z <= '0;
      in_tile_edges <= '0;
      in_north_known <= 1'b0;
      in_north_height <= '0;
      in_entry_colour <= '0;
      in_entry_shade <= mtps_pkg::SHADE_DARK;
      in_entry_flags <= '0;
    end
    cfg_valid <= 1'b0;
    cfg_index <= mtps_pkg::REG_CHUNK_GRID_ON;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    set_regs(1'b0, 1'b0, 16'hFFFF, 16'h0000);
    load_entry(16'd1, 2'b01);
    load_entry(16'd2, 2'b11);
    send_word(write_word(16'd255, mtps_pkg::SHADE_DARK, 16'hFFFF, 2'b01));
    send_word(write_word(16'd255, mtps_pkg::SHADE_NORMAL, 16'h0000, 2'b01));
    send_word(write_word(16'd255, mtps_pkg::SHADE_BRIGHT, 16'hFFFF, 2'b01));
    send_word(write_word(16'(ENTRIES), mtps_pkg::SHADE_NORMAL, 16'h5A5A, 2'b11));
    send_word(write_word(16'hFFFF, mtps_pkg::SHADE_BRIGHT, 16'hA5A5, 2'b01));
    send_word(write_word(16'd3, 2'd3, 16'h1234, 2'b11));
    // row zero: flat without a northern neighbour, then above, below, level
    send_word(pixel_word(16'd1, 8'd100, 8'd0, 4'd15, 4'd0, 2'd0, 1'b0, 8'd200));
    send_word(pixel_word(16'd1, 8'd100, 8'd0, 4'd15, 4'd0, 2'd0, 1'b1, 8'd99));
    send_word(pixel_word(16'd1, 8'd100, 8'd0, 4'd15, 4'd0, 2'd0, 1'b1, 8'd101));
    send_word(pixel_word(16'd1, 8'd100, 8'd0, 4'd15, 4'd0, 2'd0, 1'b1, 8'd100));
    send_word(pixel_word(16'd1, 8'd255, 8'd0, 4'd15, 4'd1, 2'd3, 1'b0, 8'd0));
    send_word(pixel_word(16'd1, 8'd0, 8'd255, 4'd15, 4'd2, 2'd3, 1'b0, 8'd0));
    send_word(pixel_word(16'd1, 8'd0, 8'd0, 4'd15, 4'd15, 2'd3, 1'b1, 8'd255));
    // water depth thresholds on both dither phases, then a land id, out-of-range ids and an unknown id
    send_word(pixel_word(16'd2, 8'd7, 8'd0, 4'd1, 4'd1, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'd2, 8'd7, 8'd3, 4'd0, 4'd1, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'd2, 8'd7, 8'd4, 4'd2, 4'd2, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'd2, 8'd7, 8'd9, 4'd3, 4'd3, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'd2, 8'd7, 8'd8, 4'd3, 4'd4, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'd2, 8'd7, 8'd255, 4'd15, 4'd14, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'd255, 8'd9, 8'd0, 4'd5, 4'd5, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'(ENTRIES), 8'd9, 8'd0, 4'd5, 4'd6, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'hFFFF, 8'd9, 8'd0, 4'd5, 4'd7, 2'd0, 1'b0, 8'd0));
    send_word(pixel_word(16'd3, 8'd9, 8'd0, 4'd5, 4'd8, 2'd0, 1'b0, 8'd0));
    // flags-only write turns the water entry into land
    send_word(write_word(16'd2, 2'd3, 16'h0F0F, 2'b01));
    send_word(pixel_word(16'd2, 8'd10, 8'd0, 4'd5, 4'd9, 2'd0, 1'b0, 8'd0));
    drain();

    set_regs(1'b1, 1'b1, 16'h0000, 16'hFFFF);
    for (int e = 0; e < 4; e++) begin
      send_word(pixel_word(16'd1, 8'd50, 8'd0, 4'd0, 4'd3, 2'(e), 1'b1, 8'd40));
      send_word(pixel_word(16'd1, 8'd50, 8'd0, 4'd6, 4'd0, 2'(e), 1'b1, 8'd40));
    end
    drain();

    for (int p = 0; p < 5; p++) begin
      rand_unexp = 16'($urandom);
      rand_gcol = 16'($urandom);
      case (p)
        0: set_regs(1'b0, 1'b0, 16'h0000, 16'h0000);
        1: set_regs(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        2: set_regs(1'b1, 1'b0, rand_unexp, rand_gcol);
        3: set_regs(1'b0, 1'b1, rand_unexp, rand_gcol);
        default: set_regs(1'($urandom), 1'($urandom), rand_unexp, rand_gcol);
      endcase
      if (p == 4) idle_on = 1'b0;
      random_phase(PHASE_WORDS);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_map_tile_pixel_shader_unit: PASS");
    end else begin
      $display("tb_map_tile_pixel_shader_unit: FAIL");
    end
    $finish;
  end

endmodule
